>>> src/rmsmm_pkg.sv
// Shared constants, codes and types of the running statistics unit.
package rmsmm_pkg;

   localparam int MEAN_EXTRA       = 16;
   localparam int DEF_SAMPLE_BITS  = 32;
   localparam int DEF_COUNT_BITS   = 32;
   localparam int OPND_BITS        = 64;
   localparam int REM_BITS         = OPND_BITS + 2;
   localparam int STEP_BITS        = 7;
   localparam int ROOT_STEPS       = OPND_BITS / 2;
   localparam int OUT_BITS         = 32;
   localparam int STD_BITS         = 31;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_MISS  = 2'd1;
   localparam logic [1:0] OP_SKIP  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] MODE_DIV  = 2'd0;
   localparam logic [1:0] MODE_MUL  = 2'd1;
   localparam logic [1:0] MODE_SQRT = 2'd2;

   typedef struct packed {
      logic                 start;
      logic [1:0]           mode;
      logic [STEP_BITS-1:0] steps;
      logic [OPND_BITS-1:0] opnd;    // divisor or multiplicand
      logic [OPND_BITS-1:0] shift;   // dividend, multiplier or radicand
   } iter_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [OPND_BITS-1:0] q;
      logic [REM_BITS-1:0]  r;
   } iter_rsp_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] sample_count;
      logic [OUT_BITS-1:0] mean;
      logic [OUT_BITS-1:0] minimum;
      logic [OUT_BITS-1:0] maximum;
      logic [STD_BITS-1:0] std_dev;
      logic                poisoned;
      logic                has_data;
      logic                has_spread;
   } stats_type;

endpackage

>>> src/rmsmm_iter.sv
// Shared iterative unit: restoring divide, shift-add multiply, integer square root.
module rmsmm_iter
   import rmsmm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  iter_cmd_type cmd,
   output iter_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0]           mode_ff, mode_in;
   logic [OPND_BITS-1:0] a_ff, a_in;
   logic [OPND_BITS-1:0] s_ff, s_in;
   logic [OPND_BITS-1:0] q_ff, q_in;
   logic [REM_BITS-1:0]  r_ff, r_in;

   logic [REM_BITS-1:0]  x, y, sum;
   logic                 sub, neg;

   // single shared adder
   always_comb begin
      unique case (mode_ff)
         MODE_DIV: begin
            x   = {r_ff[REM_BITS-3:0], s_ff[OPND_BITS-1]};
            y   = {2'b00, a_ff};
            sub = 1'b1;
         end
         MODE_MUL: begin
            x   = r_ff;
            y   = s_ff[0] ? {2'b00, a_ff} : '0;
            sub = 1'b0;
         end
         MODE_SQRT: begin
            x   = {r_ff[REM_BITS-3:0], s_ff[OPND_BITS-1:OPND_BITS-2]};
            y   = {q_ff, 2'b01};
            sub = 1'b1;
         end
         default: begin
            x   = r_ff;
            y   = '0;
            sub = 1'b0;
         end
      endcase
      sum = x + (sub ? ~y : y) + REM_BITS'(sub);
      neg = sub & sum[REM_BITS-1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      a_in    = a_ff;
      s_in    = s_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         mode_in = cmd.mode;
         a_in    = cmd.opnd;
         s_in    = cmd.shift;
         q_in    = '0;
         r_in    = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         unique case (mode_ff)
            MODE_MUL: begin
               r_in = {1'b0, sum[REM_BITS-1:1]};
               q_in = {sum[0], q_ff[OPND_BITS-1:1]};
               s_in = {1'b0, s_ff[OPND_BITS-1:1]};
            end
            MODE_SQRT: begin
               r_in = neg ? x : sum;
               q_in = {q_ff[OPND_BITS-2:0], ~neg};
               s_in = {s_ff[OPND_BITS-3:0], 2'b00};
            end
            default: begin
               r_in = neg ? x : sum;
               q_in = {q_ff[OPND_BITS-2:0], ~neg};
               s_in = {s_ff[OPND_BITS-2:0], 1'b0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      a_ff    <= a_in;
      s_ff    <= s_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
   end

   assign rsp.done = done_ff;
   assign rsp.q    = q_ff;
   assign rsp.r    = r_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("iterative unit started while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held for more than one cycle");
   a_start_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> cmd.steps != '0)
      else $error("iterative unit started with no steps");
`endif

endmodule

>>> src/rmsmm_ctrl.sv
// Sequencer and statistics registers driving the shared iterative unit.
module rmsmm_ctrl
   import rmsmm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          opcode,
   input  logic [OUT_BITS-1:0] sample,
   input  logic                rsp_free,
   output logic                idle,
   output logic                done,
   output stats_type           stats,
   output iter_cmd_type        cmd,
   input  iter_rsp_type        rsp
);

   localparam int AW = SAMPLE_BITS + MEAN_EXTRA;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_MEAN_GO   = 4'd1;
   localparam logic [3:0] S_MEAN_WAIT = 4'd2;
   localparam logic [3:0] S_SQ_GO     = 4'd3;
   localparam logic [3:0] S_SQ_WAIT   = 4'd4;
   localparam logic [3:0] S_VAR_GO    = 4'd5;
   localparam logic [3:0] S_VAR_WAIT  = 4'd6;
   localparam logic [3:0] S_ROOT_GO   = 4'd7;
   localparam logic [3:0] S_ROOT_WAIT = 4'd8;
   localparam logic [3:0] S_DONE      = 4'd9;

   logic [3:0]                    state_ff, state_in;
   logic                          poison_ff, poison_in;
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [AW-1:0]          mean_ff, mean_in;
   logic [OPND_BITS-1:0]          m2_ff, m2_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in, max_ff, max_in;
   logic [STD_BITS-1:0]           sd_ff, sd_in;
   logic signed [AW-1:0]          xs_ff, xs_in;
   logic [AW-1:0]                 d1mag_ff, d1mag_in;
   logic                          d1neg_ff, d1neg_in;

   logic signed [SAMPLE_BITS-1:0] x;
   logic signed [AW-1:0]          xs_new;
   logic [AW:0]                   d1, d2;
   logic [AW-1:0]                 d2mag, qmag;
   logic [2*AW-1:0]               pfull;
   logic [OPND_BITS-1:0]          prod;
   logic [OPND_BITS:0]            m2sum;

   always_comb begin
      x      = signed'(sample[SAMPLE_BITS-1:0]);
      xs_new = {sample[SAMPLE_BITS-1:0], {MEAN_EXTRA{1'b0}}};
      d1     = {xs_new[AW-1], xs_new} - {mean_ff[AW-1], mean_ff};
      d2     = {xs_ff[AW-1], xs_ff} - {mean_ff[AW-1], mean_ff};
      d2mag  = d2[AW] ? AW'(-d2) : d2[AW-1:0];
      qmag   = rsp.q[AW-1:0];
      pfull  = {rsp.r[AW-1:0], rsp.q[OPND_BITS-1 -: AW]};
      prod   = OPND_BITS'(pfull >> (2 * MEAN_EXTRA));
      m2sum  = {1'b0, m2_ff} + {1'b0, prod};
   end

   always_comb begin
      state_in  = state_ff;
      poison_in = poison_ff;
      count_in  = count_ff;
      mean_in   = mean_ff;
      m2_in     = m2_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      sd_in     = sd_ff;
      xs_in     = xs_ff;
      d1mag_in  = d1mag_ff;
      d1neg_in  = d1neg_ff;
      cmd       = '0;
      done      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DONE;
               unique case (opcode)
                  OP_ADD: begin
                     if (count_ff != '1) begin
                        count_in = count_ff + 1'b1;
                     end
                     xs_in    = xs_new;
                     d1neg_in = d1[AW];
                     d1mag_in = d1[AW] ? AW'(-d1) : d1[AW-1:0];
                     if (count_ff == '0) begin
                        min_in = x;
                        max_in = x;
                     end else begin
                        if (x < min_ff) min_in = x;
                        if (x > max_ff) max_in = x;
                     end
                     state_in = S_MEAN_GO;
                  end
                  OP_MISS: poison_in = 1'b1;
                  OP_SKIP: ;
                  default: begin
                     poison_in = 1'b0;
                     count_in  = '0;
                     mean_in   = '0;
                     m2_in     = '0;
                     min_in    = '0;
                     max_in    = '0;
                     sd_in     = '0;
                  end
               endcase
            end
         end
         S_MEAN_GO: begin
            cmd.start = 1'b1;
            cmd.mode  = MODE_DIV;
            cmd.steps = STEP_BITS'(AW);
            cmd.opnd  = OPND_BITS'(count_ff);
            cmd.shift = OPND_BITS'(d1mag_ff) << (OPND_BITS - AW);
            state_in  = S_MEAN_WAIT;
         end
         S_MEAN_WAIT: begin
            if (rsp.done) begin
               mean_in  = d1neg_ff ? mean_ff - signed'(qmag) : mean_ff + signed'(qmag);
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO: begin
            cmd.start = 1'b1;
            cmd.mode  = MODE_MUL;
            cmd.steps = STEP_BITS'(AW);
            cmd.opnd  = OPND_BITS'(d1mag_ff);
            cmd.shift = OPND_BITS'(d2mag);
            state_in  = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (rsp.done) begin
               m2_in = m2sum[OPND_BITS] ? '1 : m2sum[OPND_BITS-1:0];
               if (count_ff[COUNT_BITS-1:1] != '0) begin
                  state_in = S_VAR_GO;
               end else begin
                  sd_in    = '0;
                  state_in = S_DONE;
               end
            end
         end
         S_VAR_GO: begin
            cmd.start = 1'b1;
            cmd.mode  = MODE_DIV;
            cmd.steps = STEP_BITS'(OPND_BITS);
            cmd.opnd  = OPND_BITS'(count_ff);
            cmd.shift = m2_ff;
            state_in  = S_VAR_WAIT;
         end
         S_VAR_WAIT: begin
            if (rsp.done) state_in = S_ROOT_GO;
         end
         S_ROOT_GO: begin
            cmd.start = 1'b1;
            cmd.mode  = MODE_SQRT;
            cmd.steps = STEP_BITS'(ROOT_STEPS);
            cmd.shift = rsp.q;
            state_in  = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: begin
            if (rsp.done) begin
               sd_in    = rsp.q[STD_BITS] ? '1 : rsp.q[STD_BITS-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         poison_ff <= 1'b0;
         count_ff  <= '0;
         mean_ff   <= '0;
         m2_ff     <= '0;
         min_ff    <= '0;
         max_ff    <= '0;
         sd_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         poison_ff <= poison_in;
         count_ff  <= count_in;
         mean_ff   <= mean_in;
         m2_ff     <= m2_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         sd_ff     <= sd_in;
      end
      xs_ff    <= xs_in;
      d1mag_ff <= d1mag_in;
      d1neg_ff <= d1neg_in;
   end

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      stats.sample_count = OUT_BITS'(count_ff);
      stats.mean         = OUT_BITS'(signed'(mean_ff[AW-1:MEAN_EXTRA]));
      stats.minimum      = OUT_BITS'(min_ff);
      stats.maximum      = OUT_BITS'(max_ff);
      stats.std_dev      = sd_ff;
      stats.poisoned     = poison_ff;
      stats.has_data     = (count_ff != '0);
      stats.has_spread   = (count_ff[COUNT_BITS-1:1] != '0);
   end

`ifndef SYNTHESIS
   a_no_data_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (mean_ff == '0 && min_ff == '0 && max_ff == '0))
      else $error("statistics nonzero with no samples");
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      min_ff <= max_ff)
      else $error("minimum above maximum");
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '1 && state_ff != S_IDLE) |=> count_ff == '1)
      else $error("saturated count moved during an item");
`endif

endmodule

>>> src/running_mean_std_min_max_unit.sv
// Running mean, standard deviation, minimum and maximum of a sample stream.
//
// Input channel (req_): one beat is one command in req_opcode: add the signed
// fixed-point req_sample, mark a missing sample (sets poisoned), skip a NaN
// sample, or clear all statistics. Output channel (rsp_): exactly one beat per
// command, showing the statistics after that command: count, mean, minimum,
// maximum, population standard deviation and the poisoned/has_data/has_spread
// flags.
// An add runs the mean divide, the squared-deviation multiply, the variance divide
// and the square root in turn on the shared iterative unit, one bit per cycle. While
// fewer than two samples are held the variance divide and root are skipped. Missing,
// skip and clear go straight to the output step without the iterative unit.
// One command is in flight at a time; req_ready is high only while idle.
// Results sit in an output register, so a finished beat waits there while the
// next command is computed; a stalled receiver holds the sequencer at its last
// step until the register frees.
// Reset clears all statistics and drops any pending result.
module running_mean_std_min_max_unit
   import rmsmm_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_opcode,
   input  logic signed [OUT_BITS-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUT_BITS-1:0]        rsp_sample_count,
   output logic signed [OUT_BITS-1:0] rsp_mean,
   output logic signed [OUT_BITS-1:0] rsp_minimum,
   output logic signed [OUT_BITS-1:0] rsp_maximum,
   output logic [STD_BITS-1:0]        rsp_std_dev,
   output logic                       rsp_poisoned,
   output logic                       rsp_has_data,
   output logic                       rsp_has_spread
);

   iter_cmd_type cmd;
   iter_rsp_type irsp;
   stats_type    stats;
   stats_type    out_ff, out_in;
   logic         valid_ff, valid_in;
   logic         idle, done, rsp_free, accept;

   // output slot is free when empty or being drained this cycle
   assign rsp_free  = !valid_ff || rsp_ready;
   assign req_ready = idle;
   assign accept    = req_valid && idle;

   rmsmm_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .opcode   (req_opcode),
      .sample   (req_sample),
      .rsp_free (rsp_free),
      .idle     (idle),
      .done     (done),
      .stats    (stats),
      .cmd      (cmd),
      .rsp      (irsp)
   );

   rmsmm_iter u_iter (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (irsp)
   );

   // load a finished beat, drop the valid once taken
   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (done) begin
         valid_in = 1'b1;
         out_in   = stats;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sample_count = out_ff.sample_count;
   assign rsp_mean         = signed'(out_ff.mean);
   assign rsp_minimum      = signed'(out_ff.minimum);
   assign rsp_maximum      = signed'(out_ff.maximum);
   assign rsp_std_dev      = out_ff.std_dev;
   assign rsp_poisoned     = out_ff.poisoned;
   assign rsp_has_data     = out_ff.has_data;
   assign rsp_has_spread   = out_ff.has_spread;

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second command taken while busy");
   a_spread_has_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_spread |-> rsp_has_data)
      else $error("spread flagged without data");
   a_no_spread_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_spread |-> rsp_std_dev == '0)
      else $error("deviation nonzero below two samples");
`endif

endmodule
